FILE: rtl/kwsc_pkg.sv
// Package for the keyword substitution cipher.
// Holds action codes, ASCII constants, shared structs and the letter decoder.
// No dependencies.
`timescale 1ns / 1ps

package kwsc_pkg;

  localparam int unsigned LETTERS = 26;

  // Action codes
  localparam logic [2:0] ACT_CLEAR    = 3'd0;
  localparam logic [2:0] ACT_KEY      = 3'd1;
  localparam logic [2:0] ACT_COMPLETE = 3'd2;
  localparam logic [2:0] ACT_ENCRYPT  = 3'd3;
  localparam logic [2:0] ACT_DECRYPT  = 3'd4;

  // ASCII bounds
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5A;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOOK
  } state_t;

  // Decoded character
  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } letter_t;

  // Request to the placement unit
  typedef struct packed {
    logic       en;
    logic [4:0] idx;
  } place_req_t;

  // Table write: cipher[pos] <= letter, inverse[letter] <= pos
  typedef struct packed {
    logic       we;
    logic [4:0] pos;
    logic [4:0] letter;
  } tbl_wr_t;

  // Letter index of an ASCII character, either case
  function automatic letter_t letter_of(input logic [7:0] c);
    letter_t    r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      d = c - UPPER_A;
      r.hit = 1'b1;
    end else if (c >= LOWER_A && c <= LOWER_Z) begin
      d = c - LOWER_A;
      r.hit = 1'b1;
    end
    r.idx = d[4:0];
    return r;
  endfunction

endpackage

FILE: rtl/kwsc_if.sv
// Handshake channels for the keyword substitution cipher.
// Request channel carries action and char_in; result channel char_out and not_ready.
// No dependencies.
`timescale 1ns / 1ps

interface kwsc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface kwsc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       not_ready;

  modport source (output valid, output char_out, output not_ready, input ready);
  modport sink   (input valid, input char_out, input not_ready, output ready);
endinterface

FILE: rtl/kwsc_place_unit.sv
// Shared letter placement unit: checks one letter against the used mask and fill.
// Uses kwsc_pkg structs. Combinational; driven once per cycle by the sequencer.
`timescale 1ns / 1ps

module kwsc_place_unit (
  input  kwsc_pkg::place_req_t req,
  input  logic [25:0]          used,
  input  logic [4:0]           fill,
  output kwsc_pkg::tbl_wr_t    wr,
  output logic [25:0]          used_upd,
  output logic [4:0]           fill_upd
);

  localparam logic [4:0] FULL = 5'(kwsc_pkg::LETTERS);

  logic placed;

  // Place only a new letter while the table has room
  always_comb begin
    placed = req.en && (req.idx < FULL) && (fill < FULL) && !used[req.idx];
    wr.we     = placed;
    wr.pos    = fill;
    wr.letter = req.idx;
    used_upd  = used;
    fill_upd  = fill;
    if (placed) begin
      used_upd = used | (26'd1 << req.idx);
      fill_upd = fill + 5'd1;
    end
  end

endmodule

FILE: rtl/kwsc_tables.sv
// Cipher and inverse tables, 26 x 5 bits each, with registered read.
// Uses kwsc_pkg::tbl_wr_t. Contents are undefined until written.
`timescale 1ns / 1ps

module kwsc_tables (
  input  logic              clk,
  input  kwsc_pkg::tbl_wr_t wr,
  input  logic              rd_en,
  input  logic [4:0]        rd_addr,
  output logic [4:0]        rd_cipher,
  output logic [4:0]        rd_inverse
);

  logic [4:0] cipher_mem  [kwsc_pkg::LETTERS];
  logic [4:0] inverse_mem [kwsc_pkg::LETTERS];

  // Write both directions of one placement
  always_ff @(posedge clk) begin
    if (wr.we) begin
      cipher_mem[wr.pos]     <= wr.letter;
      inverse_mem[wr.letter] <= wr.pos;
    end
  end

  // Registered lookup; holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cipher  <= cipher_mem[rd_addr];
      rd_inverse <= inverse_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/keyword_substitution_cipher.sv
// Keyword substitution cipher: a one-request-at-a-time sequencer around a shared
// placement unit and the cipher/inverse tables. A clear or keyword request is
// done in the cycle that takes it, a complete request has the placement unit walk
// the letters from Z down to A, one per cycle, and an encrypt or decrypt request
// does a registered table read and then any wait on the result
// register. Keyword, clear and complete requests are taken while a result is
// still waiting to be collected. Uses kwsc_pkg, kwsc_if, kwsc_place_unit and
// kwsc_tables.
`timescale 1ns / 1ps

module keyword_substitution_cipher (
  input logic      clk,
  input logic      rst,
  kwsc_req_if.sink req,
  kwsc_rsp_if.source rsp
);

  localparam logic [4:0] FULL = 5'(kwsc_pkg::LETTERS);
  localparam logic [4:0] LAST = 5'(kwsc_pkg::LETTERS - 1);

  kwsc_pkg::state_t state, state_next;

  logic [25:0] used, used_next;
  logic [4:0]  fill, fill_next;
  logic        rdy, rdy_next;
  logic [4:0]  k, k_next;

  logic        out_valid, out_valid_next;
  logic [7:0]  out_char;
  logic        out_nr;
  logic        out_load;
  logic [7:0]  res;

  // Latched lookup request
  logic        lk_pass;
  logic        lk_enc;
  logic        lk_lower;
  logic [7:0]  lk_char;

  logic        req_fire;
  logic        look_req;
  kwsc_pkg::letter_t    lh;
  kwsc_pkg::place_req_t place_req;
  kwsc_pkg::tbl_wr_t    tbl_wr;
  logic [25:0] pl_used;
  logic [4:0]  pl_fill;
  logic [4:0]  rd_cipher;
  logic [4:0]  rd_inverse;

  assign req.ready = (state == kwsc_pkg::ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign lh        = kwsc_pkg::letter_of(req.char_in);
  assign look_req  = req_fire && (req.action == kwsc_pkg::ACT_ENCRYPT ||
                                  req.action == kwsc_pkg::ACT_DECRYPT);

  kwsc_place_unit u_place (
    .req      (place_req),
    .used     (used),
    .fill     (fill),
    .wr       (tbl_wr),
    .used_upd (pl_used),
    .fill_upd (pl_fill)
  );

  kwsc_tables u_tables (
    .clk        (clk),
    .wr         (tbl_wr),
    .rd_en      (look_req),
    .rd_addr    (lh.idx),
    .rd_cipher  (rd_cipher),
    .rd_inverse (rd_inverse)
  );

  // Result character from the table read, or the input character passed through
  always_comb begin
    if (lk_pass) begin
      res = lk_char;
    end else if (lk_enc) begin
      res = kwsc_pkg::UPPER_A + {3'b000, rd_cipher};
    end else if (lk_lower) begin
      res = kwsc_pkg::LOWER_A + {3'b000, rd_inverse};
    end else begin
      res = kwsc_pkg::UPPER_A + {3'b000, rd_inverse};
    end
  end

  // Sequencer: next state and placement requests
  always_comb begin
    state_next = state;
    used_next  = used;
    fill_next  = fill;
    rdy_next   = rdy;
    k_next     = k;
    out_load   = 1'b0;
    place_req  = '{en: 1'b0, idx: k};
    case (state)
      kwsc_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (req.action)
            kwsc_pkg::ACT_CLEAR: begin
              used_next = '0;
              fill_next = '0;
              rdy_next  = 1'b0;
            end
            kwsc_pkg::ACT_KEY: begin
              if (!rdy && lh.hit) begin
                place_req = '{en: 1'b1, idx: lh.idx};
                used_next = pl_used;
                fill_next = pl_fill;
              end
            end
            kwsc_pkg::ACT_COMPLETE: begin
              if (!rdy) begin
                k_next     = LAST;
                state_next = kwsc_pkg::ST_WALK;
              end
            end
            kwsc_pkg::ACT_ENCRYPT, kwsc_pkg::ACT_DECRYPT: begin
              state_next = kwsc_pkg::ST_LOOK;
            end
            default: ;
          endcase
        end
      end
      kwsc_pkg::ST_WALK: begin
        place_req = '{en: 1'b1, idx: k};
        used_next = pl_used;
        fill_next = pl_fill;
        if (k == 5'd0) begin
          rdy_next   = 1'b1;
          state_next = kwsc_pkg::ST_IDLE;
        end else begin
          k_next = k - 5'd1;
        end
      end
      kwsc_pkg::ST_LOOK: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = kwsc_pkg::ST_IDLE;
        end
      end
      default: state_next = kwsc_pkg::ST_IDLE;
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kwsc_pkg::ST_IDLE;
      used      <= '0;
      fill      <= '0;
      rdy       <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      fill      <= fill_next;
      rdy       <= rdy_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (look_req) begin
      lk_pass  <= !(rdy && lh.hit);
      lk_enc   <= (req.action == kwsc_pkg::ACT_ENCRYPT);
      lk_lower <= (req.char_in >= kwsc_pkg::LOWER_A);
      lk_char  <= req.char_in;
    end
    if (out_load) begin
      out_char <= res;
      out_nr   <= !rdy;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.char_out  = out_char;
  assign rsp.not_ready = out_nr;

  // Fill count tracks the used mask
  a_fill_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == 32'(fill))
    else $error("fill count disagrees with used letter mask");

  // A completed alphabet holds every letter
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    rdy |-> (fill == FULL))
    else $error("alphabet marked complete with missing letters");

  // The walk runs only on an incomplete alphabet
  a_walk_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == kwsc_pkg::ST_WALK) |-> !rdy)
    else $error("completion walk on a complete alphabet");

  // A lookup leaves only by loading the result register
  a_look_loads: assert property (@(posedge clk) disable iff (rst)
    (state == kwsc_pkg::ST_LOOK) && (state_next == kwsc_pkg::ST_IDLE) |=> out_valid)
    else $error("lookup finished without a result");

endmodule

FILE: tb/tb_keyword_substitution_cipher.sv
// Testbench for keyword_substitution_cipher: directed table, then random alphabets and text.
// Results are checked against an in-bench model of the cipher tables, or against a directed row's typed expectation.
// Depends on kwsc_pkg, kwsc_if and the keyword_substitution_cipher RTL.
`timescale 1ns / 1ps

module tb_keyword_substitution_cipher;

  localparam int ITEMS       = 1250;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 40;     // covers the letter walk of a complete request
  localparam int HOLD_CYCLES = 400;    // one long result stall
  localparam int BURST       = 50;

  // Action codes the block must ignore
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       nr;
  } letter_result_t;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] ch;
  } req_item_t;

  // Directed row: expectation typed in only where marked
  typedef struct packed {
    logic [2:0] act;
    logic [7:0] ch;
    logic       typed;
    logic [7:0] exp_ch;
    logic       exp_nr;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{kwsc_pkg::ACT_ENCRYPT,  "A",   1'b1, "A",   1'b1},  // after reset: pass through
    '{kwsc_pkg::ACT_DECRYPT,  "z",   1'b1, "z",   1'b1},
    '{kwsc_pkg::ACT_KEY,      "k",   1'b0, 8'h00, 1'b0},
    '{kwsc_pkg::ACT_KEY,      "E",   1'b0, 8'h00, 1'b0},
    '{kwsc_pkg::ACT_KEY,      "k",   1'b0, 8'h00, 1'b0},  // repeat letter
    '{kwsc_pkg::ACT_KEY,      "1",   1'b0, 8'h00, 1'b0},  // non-letter
    '{kwsc_pkg::ACT_KEY,      8'hFF, 1'b0, 8'h00, 1'b0},
    '{kwsc_pkg::ACT_COMPLETE, 8'h00, 1'b0, 8'h00, 1'b0},
    '{kwsc_pkg::ACT_COMPLETE, 8'hFF, 1'b0, 8'h00, 1'b0},  // already complete
    '{kwsc_pkg::ACT_KEY,      "Q",   1'b0, 8'h00, 1'b0},  // keyword after completion
    '{kwsc_pkg::ACT_ENCRYPT,  "A",   1'b1, "K",   1'b0},
    '{kwsc_pkg::ACT_ENCRYPT,  "b",   1'b1, "E",   1'b0},
    '{kwsc_pkg::ACT_ENCRYPT,  "z",   1'b1, "A",   1'b0},
    '{kwsc_pkg::ACT_DECRYPT,  "K",   1'b1, "A",   1'b0},
    '{kwsc_pkg::ACT_DECRYPT,  "e",   1'b1, "b",   1'b0},
    '{kwsc_pkg::ACT_ENCRYPT,  8'h00, 1'b1, 8'h00, 1'b0},
    '{kwsc_pkg::ACT_DECRYPT,  8'hFF, 1'b1, 8'hFF, 1'b0},
    '{kwsc_pkg::ACT_ENCRYPT,  8'h40, 1'b1, 8'h40, 1'b0},  // just below 'A'
    '{kwsc_pkg::ACT_DECRYPT,  8'h7B, 1'b1, 8'h7B, 1'b0},  // just above 'z'
    '{ACT_RSVD5,              8'h5A, 1'b0, 8'h00, 1'b0},
    '{ACT_RSVD6,              8'hAA, 1'b0, 8'h00, 1'b0},
    '{ACT_RSVD7,              8'h55, 1'b0, 8'h00, 1'b0},
    '{kwsc_pkg::ACT_CLEAR,    8'h00, 1'b0, 8'h00, 1'b0},
    '{kwsc_pkg::ACT_ENCRYPT,  "M",   1'b1, "M",   1'b1},  // cleared: not ready again
    '{kwsc_pkg::ACT_KEY,      "z",   1'b0, 8'h00, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  kwsc_req_if req_ch ();
  kwsc_rsp_if rsp_ch ();

  keyword_substitution_cipher dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Typed expectation travelling with the request on the bus
  logic       cur_typed  = 1'b0;
  logic [7:0] cur_exp_ch = 8'h00;
  logic       cur_exp_nr = 1'b0;

  letter_result_t pending_chars[$];

  int n_sent    = 0;
  int n_eff     = 0;
  int n_results = 0;
  int n_built   = 0;
  int n_full    = 0;
  int n_err     = 0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  // Cipher model state
  logic [4:0]  enc_tbl [kwsc_pkg::LETTERS];
  logic [4:0]  dec_tbl [kwsc_pkg::LETTERS];
  logic [25:0] used_set   = '0;
  int          fill_cnt   = 0;
  bit          alpha_done = 1'b0;

  function automatic bit place_letter(input logic [4:0] idx);
    if (fill_cnt >= kwsc_pkg::LETTERS || used_set[idx]) return 1'b0;
    enc_tbl[fill_cnt] = idx;
    dec_tbl[idx] = 5'(fill_cnt);
    used_set[idx] = 1'b1;
    fill_cnt++;
    return 1'b1;
  endfunction

  // Applies one request to the model; returns 1 if it did anything
  function automatic bit predict_cipher(input logic [2:0] act, input logic [7:0] ch,
                                        output bit has_out, output letter_result_t res);
    bit         is_ltr;
    bit         took;
    logic [4:0] idx;
    is_ltr = 1'b0;
    took = 1'b0;
    idx = '0;
    has_out = 1'b0;
    res.ch = ch;
    if (ch >= kwsc_pkg::UPPER_A && ch <= kwsc_pkg::UPPER_Z) begin
      is_ltr = 1'b1;
      idx = 5'(ch - kwsc_pkg::UPPER_A);
    end else if (ch >= kwsc_pkg::LOWER_A && ch <= kwsc_pkg::LOWER_Z) begin
      is_ltr = 1'b1;
      idx = 5'(ch - kwsc_pkg::LOWER_A);
    end
    case (act)
      kwsc_pkg::ACT_CLEAR: begin
        used_set = '0;
        fill_cnt = 0;
        alpha_done = 1'b0;
        took = 1'b1;
      end
      kwsc_pkg::ACT_KEY: begin
        if (!alpha_done && is_ltr) took = place_letter(idx);
        if (took && fill_cnt == kwsc_pkg::LETTERS) n_full++;
      end
      kwsc_pkg::ACT_COMPLETE: begin
        if (!alpha_done) begin
          for (int k = kwsc_pkg::LETTERS - 1; k >= 0; k--) void'(place_letter(5'(k)));
          alpha_done = 1'b1;
          took = 1'b1;
          n_built++;
        end
      end
      kwsc_pkg::ACT_ENCRYPT: begin
        has_out = 1'b1;
        took = 1'b1;
        if (alpha_done && is_ltr) res.ch = kwsc_pkg::UPPER_A + 8'(enc_tbl[idx]);
      end
      kwsc_pkg::ACT_DECRYPT: begin
        has_out = 1'b1;
        took = 1'b1;
        if (alpha_done && is_ltr)
          res.ch = ((ch >= kwsc_pkg::LOWER_A) ? kwsc_pkg::LOWER_A : kwsc_pkg::UPPER_A)
                   + 8'(dec_tbl[idx]);
      end
      default: ;
    endcase
    res.nr = !alpha_done;
    return took;
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(0, 25))
           + ($urandom_range(0, 1) ? kwsc_pkg::LOWER_A : kwsc_pkg::UPPER_A);
  endfunction

  function automatic logic [7:0] rand_text();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : rand_letter();
  endfunction

  // Present one request at a falling edge and hold it until taken
  task automatic drive_req(input logic [2:0] act, input logic [7:0] ch, input logic typed,
                           input logic [7:0] exp_ch, input logic exp_nr);
    int gap;
    if (n_sent % BURST == 0) send_quiet = ($urandom_range(0, 3) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.char_in <= ch;
    cur_typed      <= typed;
    cur_exp_ch     <= exp_ch;
    cur_exp_nr     <= exp_nr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // Check results first, then record the request taken in the same cycle
  always @(posedge clk) begin
    letter_result_t got;
    letter_result_t want;
    letter_result_t pred;
    bit             has_out;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.ch = rsp_ch.char_out;
        got.nr = rsp_ch.not_ready;
        if (pending_chars.size() == 0) begin
          n_err++;
          $display("%0t ERROR unexpected result: expected none, got char_out=%h not_ready=%b",
                   $time, got.ch, got.nr);
        end else begin
          want = pending_chars.pop_front();
          n_results++;
          if (got.ch !== want.ch) begin
            n_err++;
            $display("%0t ERROR char_out: expected %h, got %h", $time, want.ch, got.ch);
          end
          if (got.nr !== want.nr) begin
            n_err++;
            $display("%0t ERROR not_ready: expected %b, got %b", $time, want.nr, got.nr);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        if (predict_cipher(req_ch.action, req_ch.char_in, has_out, pred)) n_eff++;
        if (has_out) begin
          if (cur_typed) begin
            want.ch = cur_exp_ch;
            want.nr = cur_exp_nr;
            pending_chars.push_back(want);
          end else begin
            pending_chars.push_back(pred);
          end
        end
      end
    end
  end

  // Result side: random stalls, bursts of none, and one long hold-off
  initial begin
    int  stall;
    int  taken;
    bit  held;
    taken = 0;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken % BURST == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      if (!held && n_results >= 200) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = recv_quiet ? 0 : $urandom_range(0, 18);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t timeout with %0d results outstanding", $time, pending_chars.size());
    $display("FAIL keyword_substitution_cipher");
    $finish;
  end

  // Request side: directed table, then random sequences
  initial begin
    req_item_t  seq_q[$];
    req_item_t  it;
    logic [4:0] perm [kwsc_pkg::LETTERS];
    logic [4:0] tmp;
    int         kind;
    int         len;
    int         j;
    int         r;
    req_ch.valid   = 1'b0;
    req_ch.action  = kwsc_pkg::ACT_CLEAR;
    req_ch.char_in = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i])
      drive_req(DIR_TAB[i].act, DIR_TAB[i].ch, DIR_TAB[i].typed,
                DIR_TAB[i].exp_ch, DIR_TAB[i].exp_nr);

    while (n_sent < ITEMS) begin
      seq_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // Well-formed: clear, keyword, complete, then text
        if ($urandom_range(0, 9) != 0) begin
          it = '{kwsc_pkg::ACT_CLEAR, 8'($urandom)};
          seq_q.push_back(it);
        end
        if ($urandom_range(0, 9) == 0) begin
          // every letter in the keyword, then a few that find the table full
          for (j = 0; j < kwsc_pkg::LETTERS; j++) perm[j] = 5'(j);
          for (j = kwsc_pkg::LETTERS - 1; j > 0; j--) begin
            r = $urandom_range(0, j);
            tmp = perm[j];
            perm[j] = perm[r];
            perm[r] = tmp;
          end
          for (j = 0; j < kwsc_pkg::LETTERS; j++) begin
            it = '{kwsc_pkg::ACT_KEY, 8'(perm[j])
                   + ($urandom_range(0, 1) ? kwsc_pkg::LOWER_A : kwsc_pkg::UPPER_A)};
            seq_q.push_back(it);
          end
          repeat ($urandom_range(1, 3)) begin
            it = '{kwsc_pkg::ACT_KEY, rand_letter()};
            seq_q.push_back(it);
          end
        end else begin
          len = $urandom_range(0, 12);
          repeat (len) begin
            it = '{kwsc_pkg::ACT_KEY,
                   ($urandom_range(0, 6) == 0) ? 8'($urandom) : rand_letter()};
            seq_q.push_back(it);
          end
        end
        it = '{kwsc_pkg::ACT_COMPLETE, 8'($urandom)};
        seq_q.push_back(it);
        len = $urandom_range(4, 30);
        repeat (len) begin
          r = $urandom_range(0, 19);
          if (r == 0) it = '{kwsc_pkg::ACT_KEY, rand_letter()};
          else if (r == 1) it = '{kwsc_pkg::ACT_COMPLETE, 8'($urandom)};
          else it = '{$urandom_range(0, 1) ? kwsc_pkg::ACT_ENCRYPT : kwsc_pkg::ACT_DECRYPT,
                      rand_text()};
          seq_q.push_back(it);
        end
      end else if (kind < 85) begin
        // Broken: text without a completed alphabet (unless one survives)
        if ($urandom_range(0, 1)) begin
          it = '{kwsc_pkg::ACT_CLEAR, 8'($urandom)};
          seq_q.push_back(it);
        end
        repeat ($urandom_range(0, 8)) begin
          it = '{kwsc_pkg::ACT_KEY, rand_text()};
          seq_q.push_back(it);
        end
        repeat ($urandom_range(3, 10)) begin
          it = '{$urandom_range(0, 1) ? kwsc_pkg::ACT_ENCRYPT : kwsc_pkg::ACT_DECRYPT,
                 rand_text()};
          seq_q.push_back(it);
        end
      end else begin
        // Noise: any action code, any byte
        repeat ($urandom_range(5, 15)) begin
          it = '{3'($urandom), 8'($urandom)};
          seq_q.push_back(it);
        end
      end
      foreach (seq_q[i]) drive_req(seq_q[i].act, seq_q[i].ch, 1'b0, 8'h00, 1'b0);
    end
    req_ch.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d requests (%0d with effect), %0d results checked, %0d errors.",
             n_sent, n_eff, n_results, n_err);
    $display("Built %0d alphabets, %0d of them from a keyword that filled the table.",
             n_built, n_full);
    if (n_err == 0) begin
      $display("PASS keyword_substitution_cipher");
    end else begin
      $display("FAIL keyword_substitution_cipher");
    end
    $finish;
  end

endmodule
